// ----- hw/rtl/ssb_pkg.sv -----
// ----------------------------------------------------------------------------
// ssb_pkg
// types and constants shared by the sort-and-sweep sphere broadphase
// ----------------------------------------------------------------------------
package ssb_pkg;

  localparam int MaxObjectsDefault = 64;
  localparam int CoordBitsDefault  = 16;
  localparam int RadiusBits        = 15;
  localparam int IndexBits         = 6;
  localparam int AxisBits          = 2;

  localparam logic [AxisBits-1:0] AXIS_X = 2'd0;
  localparam logic [AxisBits-1:0] AXIS_Y = 2'd1;
  localparam logic [AxisBits-1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic signed [CoordBitsDefault-1:0] center_x;
    logic signed [CoordBitsDefault-1:0] center_y;
    logic signed [CoordBitsDefault-1:0] center_z;
    logic [RadiusBits-1:0]              sphere_radius;
    logic                               last_object;
  } sphere_in_t;

  typedef struct packed {
    logic [IndexBits-1:0] object_index;
    logic                 collided;
    logic [AxisBits-1:0]  next_axis;
    logic                 last_result;
  } sphere_out_t;

endpackage

// ----- hw/rtl/sort_and_sweep_sphere_broadphase_top.sv -----
// ----------------------------------------------------------------------------
// sort_and_sweep_sphere_broadphase_top
// loads spheres, sorts by interval start, sweeps pairs, reports flags
// ----------------------------------------------------------------------------
// loads may follow back to back while busy is low. a closing item starts the
// insertion sort of the spheres by interval start, then the sweep over the sorted
// pairs, then the variance based choice of the next axis, then the n results
// back to back. frames are handled one at a time; busy is high from after the
// closing transfer and falls as the last result appears.
// reset clears the count, the axis, the sums and the flags; the receiver cannot stall.
module sort_and_sweep_sphere_broadphase_top #(
  parameter int MaxObjects = ssb_pkg::MaxObjectsDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  ssb_pkg::sphere_in_t  item,
  output logic                 busy,
  output logic                 strobe,
  output ssb_pkg::sphere_out_t result
);
  import ssb_pkg::*;

  localparam int CoordBits = CoordBitsDefault;
  localparam int AW  = (MaxObjects > 1) ? $clog2(MaxObjects) : 1;
  localparam int CW  = AW + 1;
  localparam int EW  = ((CoordBits > RadiusBits) ? CoordBits : RadiusBits) + 2;
  localparam int S1W = CoordBits + CW;
  localparam int S2W = 2 * CoordBits + CW;
  localparam int VW  = 2 * S1W + 2;
  localparam int RW  = CoordBits * 3 + RadiusBits;

  localparam logic [4:0] S_LOAD  = 5'd0;
  localparam logic [4:0] S_SRD   = 5'd1;
  localparam logic [4:0] S_SKEY  = 5'd2;
  localparam logic [4:0] S_SORD  = 5'd3;
  localparam logic [4:0] S_SOBJ  = 5'd4;
  localparam logic [4:0] S_SCMP  = 5'd5;
  localparam logic [4:0] S_SINS  = 5'd6;
  localparam logic [4:0] S_WRD   = 5'd7;
  localparam logic [4:0] S_WA    = 5'd8;
  localparam logic [4:0] S_WALIM = 5'd9;
  localparam logic [4:0] S_WB    = 5'd10;
  localparam logic [4:0] S_WT    = 5'd11;
  localparam logic [4:0] S_WCHK  = 5'd12;
  localparam logic [4:0] S_HIT   = 5'd13;
  localparam logic [4:0] S_VMUL  = 5'd14;
  localparam logic [4:0] S_VFIN  = 5'd15;
  localparam logic [4:0] S_OUT   = 5'd16;

  logic [RW-1:0] smem [MaxObjects];
  logic [AW-1:0] omem [MaxObjects];
  logic [MaxObjects-1:0] flags;

  logic [4:0]          state;
  logic [CW-1:0]       count, i, j;
  logic [AxisBits-1:0] axis;
  logic [AW-1:0]       a_idx, b_idx, prev;
  logic signed [EW-1:0] key, lim;
  logic [RW-1:0]       a_rec;
  logic [1:0]          pipe;
  logic                store;
  logic                shift;

  // memory ports
  logic [AW-1:0] s_raddr, o_raddr;
  logic [RW-1:0] s_rdata;
  logic [AW-1:0] o_rdata;
  logic          o_we;
  logic [AW-1:0] o_waddr, o_wdata;

  // variance sums
  logic signed [S1W-1:0] s1 [3];
  logic signed [S2W-1:0] s2 [3];
  logic signed [VW-1:0]  var_v [3];
  logic signed [CoordBits-1:0]   in_c [3];
  logic signed [2*CoordBits-1:0] in_sq [3];
  logic pick_y, pick_z;

  function automatic logic signed [CoordBits-1:0] crd(input logic [RW-1:0] r,
                                                      input logic [AxisBits-1:0] ax);
    logic signed [CoordBits-1:0] v;
    case (ax)
      AXIS_Y:  v = r[RW-CoordBits-1 -: CoordBits];
      AXIS_Z:  v = r[RW-2*CoordBits-1 -: CoordBits];
      default: v = r[RW-1 -: CoordBits];
    endcase
    return v;
  endfunction

  function automatic logic signed [EW-1:0] lo(input logic [RW-1:0] r,
                                              input logic [AxisBits-1:0] ax);
    return EW'(crd(r, ax)) - signed'(EW'(r[RadiusBits-1:0]));
  endfunction

  function automatic logic signed [EW-1:0] hi(input logic [RW-1:0] r,
                                              input logic [AxisBits-1:0] ax);
    return EW'(crd(r, ax)) + signed'(EW'(r[RadiusBits-1:0]));
  endfunction

  assign busy  = (state != S_LOAD);
  assign store = start && !busy && (count < CW'(MaxObjects));
  assign shift = lo(s_rdata, axis) > key;

  always_comb begin
    in_c[0] = item.center_x;
    in_c[1] = item.center_y;
    in_c[2] = item.center_z;
    for (int k = 0; k < 3; k++) in_sq[k] = in_c[k] * in_c[k];
  end

  always_ff @(posedge clk) begin
    if (store)
      smem[count[AW-1:0]] <= {item.center_x, item.center_y, item.center_z,
                              item.sphere_radius};
    s_rdata <= smem[s_raddr];
  end

  always_ff @(posedge clk) begin
    if (o_we) omem[o_waddr] <= o_wdata;
    o_rdata <= omem[o_raddr];
  end

  // overlap pipeline
  logic hit;
  ssb_pair_test #(.CoordBits(CoordBits)) u_pair (
    .clk(clk),
    .ax(crd(a_rec, AXIS_X)), .ay(crd(a_rec, AXIS_Y)), .az(crd(a_rec, AXIS_Z)),
    .ar(a_rec[RadiusBits-1:0]),
    .bx(crd(s_rdata, AXIS_X)), .by(crd(s_rdata, AXIS_Y)), .bz(crd(s_rdata, AXIS_Z)),
    .br(s_rdata[RadiusBits-1:0]),
    .hit(hit)
  );

  always_comb begin
    s_raddr = '0;
    o_raddr = '0;
    o_we    = 1'b0;
    o_waddr = j[AW-1:0];
    o_wdata = prev;
    unique case (state)
      S_SRD:  s_raddr = i[AW-1:0];
      S_SORD: o_raddr = AW'(j - CW'(1));
      S_SOBJ: s_raddr = o_rdata;
      S_SCMP: o_we = shift;
      S_SINS: begin
        o_we    = 1'b1;
        o_wdata = i[AW-1:0];
      end
      S_WRD:  o_raddr = i[AW-1:0];
      S_WA:   s_raddr = o_rdata;
      S_WB:   o_raddr = j[AW-1:0];
      S_WT:   s_raddr = o_rdata;
      default: ;
    endcase
  end

  always_comb begin
    pick_y = var_v[1] > var_v[0];
    pick_z = var_v[2] > (pick_y ? var_v[1] : var_v[0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      count  <= '0;
      axis   <= AXIS_X;
      flags  <= '0;
      strobe <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        s1[k] <= '0;
        s2[k] <= '0;
      end
    end else begin
      strobe <= 1'b0;
      unique case (state)
        S_LOAD: if (start) begin
          if (count < CW'(MaxObjects)) begin
            count <= count + CW'(1);
            for (int k = 0; k < 3; k++) begin
              s1[k] <= s1[k] + S1W'(in_c[k]);
              s2[k] <= s2[k] + S2W'(in_sq[k]);
            end
          end
          if (item.last_object) begin
            i <= '0;
            state <= S_SRD;
          end
        end
        S_SRD: begin
          if (i == count) begin
            i <= '0;
            state <= S_WRD;
          end else begin
            j <= i;
            state <= S_SKEY;
          end
        end
        S_SKEY: begin
          key <= lo(s_rdata, axis);
          state <= (j == '0) ? S_SINS : S_SORD;
        end
        S_SORD: state <= S_SOBJ;
        S_SOBJ: begin
          prev <= o_rdata;
          state <= S_SCMP;
        end
        S_SCMP: begin
          if (shift) begin
            j <= j - CW'(1);
            state <= (j == CW'(1)) ? S_SINS : S_SORD;
          end else begin
            state <= S_SINS;
          end
        end
        S_SINS: begin
          i <= i + CW'(1);
          state <= S_SRD;
        end
        S_WRD: state <= (i == count) ? S_VMUL : S_WA;
        S_WA: begin
          a_idx <= o_rdata;
          state <= S_WALIM;
        end
        S_WALIM: begin
          a_rec <= s_rdata;
          lim   <= hi(s_rdata, axis);
          j     <= i + CW'(1);
          state <= S_WB;
        end
        S_WB: begin
          if (j == count) begin
            i <= i + CW'(1);
            state <= S_WRD;
          end else begin
            state <= S_WT;
          end
        end
        S_WT: begin
          b_idx <= o_rdata;
          state <= S_WCHK;
        end
        S_WCHK: begin
          if (lo(s_rdata, axis) > lim) begin
            i <= i + CW'(1);
            state <= S_WRD;
          end else begin
            pipe <= '0;
            state <= S_HIT;
          end
        end
        S_HIT: begin
          pipe <= pipe + 2'd1;
          if (pipe == 2'd2) begin
            if (hit) begin
              flags[a_idx] <= 1'b1;
              flags[b_idx] <= 1'b1;
            end
            j <= j + CW'(1);
            state <= S_WB;
          end
        end
        S_VMUL: begin
          for (int k = 0; k < 3; k++)
            var_v[k] <= signed'(VW'(count)) * VW'(s2[k]) - VW'(s1[k]) * VW'(s1[k]);
          i <= '0;
          state <= S_VFIN;
        end
        S_VFIN: begin
          axis <= pick_z ? AXIS_Z : (pick_y ? AXIS_Y : AXIS_X);
          state <= S_OUT;
        end
        S_OUT: begin
          strobe <= 1'b1;
          result.object_index <= IndexBits'(i);
          result.collided     <= flags[i[AW-1:0]];
          result.next_axis    <= axis;
          result.last_result  <= (i + CW'(1) == count);
          flags[i[AW-1:0]]    <= 1'b0;
          i <= i + CW'(1);
          if (i + CW'(1) == count) begin
            count <= '0;
            for (int k = 0; k < 3; k++) begin
              s1[k] <= '0;
              s2[k] <= '0;
            end
            state <= S_LOAD;
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(MaxObjects)) else $error("count overflow");
  a_state: assert property (@(posedge clk) disable iff (rst)
    state <= S_OUT) else $error("illegal state");
  a_out: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state == S_OUT)) else $error("result outside output phase");
  a_sort_we: assert property (@(posedge clk) disable iff (rst)
    o_we |-> (state == S_SCMP || state == S_SINS)) else $error("stray order write");

endmodule

// ----- hw/rtl/ssb_pair_test.sv -----
// ----------------------------------------------------------------------------
// ssb_pair_test
// pipelined sphere overlap test: squared distance against squared radius sum
// ----------------------------------------------------------------------------
module ssb_pair_test #(
  parameter int CoordBits = ssb_pkg::CoordBitsDefault
) (
  input  logic                                clk,
  input  logic signed [CoordBits-1:0]         ax,
  input  logic signed [CoordBits-1:0]         ay,
  input  logic signed [CoordBits-1:0]         az,
  input  logic [ssb_pkg::RadiusBits-1:0]      ar,
  input  logic signed [CoordBits-1:0]         bx,
  input  logic signed [CoordBits-1:0]         by,
  input  logic signed [CoordBits-1:0]         bz,
  input  logic [ssb_pkg::RadiusBits-1:0]      br,
  output logic                                hit
);
  import ssb_pkg::*;

  localparam int DW = CoordBits + 1;
  localparam int QW = 2 * RadiusBits + 2;
  localparam int SW = ((2 * DW > QW) ? 2 * DW : QW) + 2;

  logic signed [DW-1:0]   dx, dy, dz;
  logic [RadiusBits:0]    rs;
  logic signed [2*DW-1:0] qx, qy, qz;
  logic [QW-1:0]          qr;

  always_ff @(posedge clk) begin
    dx <= DW'(ax) - DW'(bx);
    dy <= DW'(ay) - DW'(by);
    dz <= DW'(az) - DW'(bz);
    rs <= (RadiusBits+1)'(ar) + (RadiusBits+1)'(br);
  end

  always_ff @(posedge clk) begin
    qx <= dx * dx;
    qy <= dy * dy;
    qz <= dz * dz;
    qr <= rs * rs;
  end

  always_ff @(posedge clk) begin
    hit <= (SW'(qx) + SW'(qy) + SW'(qz)) <= signed'(SW'(qr));
  end

endmodule
